FILE: rtl/core/gnam_pkg.sv
// Shared constants and types for the grid neighbor adjacency mask block.
package gnam_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);

    localparam int SIZE_W      = 9;
    localparam int TILE_W      = 8;
    localparam int COORD_W     = 8;
    localparam int MASK_W      = 8;
    localparam int DEG_W       = 4;
    localparam int VSUM_W      = 17;
    localparam int DSUM_W      = 20;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 9;

    localparam logic [SIZE_W-1:0] WIDTH_MAX   = SIZE_W'(MAX_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_MAX  = SIZE_W'(MAX_HEIGHT);
    localparam logic [TILE_W-1:0] ROCK_RESET   = 8'd1;
    localparam logic [TILE_W-1:0] WATER_RESET  = 8'd2;
    localparam logic [TILE_W-1:0] CRATER_RESET = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GRID_WIDTH  = 3'd0,
        REG_GRID_HEIGHT = 3'd1,
        REG_ROCK_CODE   = 3'd2,
        REG_WATER_CODE  = 3'd3,
        REG_CRATER_CODE = 3'd4
    } cfg_reg_t;

    // Pending result slots of one input, in emission order.
    typedef enum logic [1:0] {
        SLOT_UPPER_PREV = 2'd0,
        SLOT_UPPER_EDGE = 2'd1,
        SLOT_LOWER_PREV = 2'd2,
        SLOT_LOWER_EDGE = 2'd3
    } slot_t;

endpackage

FILE: rtl/core/gnam_if.sv
// Request channels of the grid neighbor adjacency mask block.
interface gnam_tile_if;
    logic                        valid;
    logic                        ready;
    logic [gnam_pkg::TILE_W-1:0] tile;

    modport source (output valid, output tile, input ready);
    modport sink   (input valid, input tile, output ready);
endinterface

interface gnam_result_if;
    logic                         valid;
    logic                         ready;
    logic [gnam_pkg::COORD_W-1:0] cell_row;
    logic [gnam_pkg::COORD_W-1:0] cell_col;
    logic                         passable;
    logic [gnam_pkg::MASK_W-1:0]  neighbor_mask;
    logic [gnam_pkg::DEG_W-1:0]   degree;
    logic [gnam_pkg::VSUM_W-1:0]  vertex_total;
    logic [gnam_pkg::DSUM_W-1:0]  degree_total;
    logic                         last;

    modport source (output valid, output cell_row, output cell_col, output passable,
                    output neighbor_mask, output degree, output vertex_total,
                    output degree_total, output last, input ready);
    modport sink   (input valid, input cell_row, input cell_col, input passable,
                    input neighbor_mask, input degree, input vertex_total,
                    input degree_total, input last, output ready);
endinterface

FILE: rtl/core/grid_neighbor_adjacency_mask.sv
// Top level: 8-connected neighbor masks of a tile map streamed in raster order.
//
// Tiles arrive one request at a time on the tiles channel (valid/ready), row-major,
// grid_height rows of grid_width columns. Each result on the results channel
// describes one cell: its passability, its mask of passable neighbors, its degree
// and the running vertex and degree totals. Results lag the input by one row and
// one column; the right edge and the bottom row are flushed, so a tile request
// yields zero to four results. The configuration port must be written only while
// idle; the block does not enforce this. An accepted tile reads the line store (a
// 256 x 2 bit synchronous memory) in the next stage, updates it and the 3x3 window,
// and hands its results to an emitter. Throughput is one tile per cycle while each
// tile yields at most one result and the receiver does not stall; a tile that yields
// several results, as on the bottom row, holds the memory stage while the single
// output register takes them one by one. Back-to-back reads of the same line store
// entry (a one-column grid) take the just-written value by forwarding. When the
// receiver stalls, the result holds in the output register and the pipeline backs up
// to the tiles channel. Reset clears position, window and totals and loads the
// default configuration; the line store is not cleared, since rows that do not exist
// yet are masked. After the last cell both totals restart.
module grid_neighbor_adjacency_mask (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gnam_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [gnam_pkg::CFG_DATA_W-1:0]  cfg_data,
    gnam_tile_if.sink                        tiles,
    gnam_result_if.source                    results
);
    import gnam_pkg::*;

    // Configuration
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [TILE_W-1:0] rock_reg;
    logic [TILE_W-1:0] water_reg;
    logic [TILE_W-1:0] crater_reg;
    logic [SIZE_W-1:0] width_eff;
    logic [SIZE_W-1:0] height_eff;

    // Input stage
    logic [ROW_W-1:0]  row_reg;
    logic [COL_W-1:0]  col_reg;
    logic              in_fire;
    logic              in_pass;
    logic              in_end_row;
    logic              in_last_row;

    // Memory stage
    logic [1:0]        line_mem [MAX_WIDTH];
    logic [1:0]        rd_data_reg;
    logic              fwd_reg;
    logic [1:0]        fwd_data_reg;
    logic              b_valid_reg;
    logic              b_pass_reg;
    logic [ROW_W-1:0]  b_row_reg;
    logic [COL_W-1:0]  b_col_reg;
    logic              b_end_row_reg;
    logic              b_last_row_reg;
    logic              b_fire;
    logic [1:0]        ls;
    logic [1:0]        ls_wr;
    logic [2:0]        col_bits;
    logic [8:0]        window_reg;
    logic [8:0]        window_next;
    logic [3:0]        todo_new;

    // Emitter
    logic [3:0]        todo_reg;
    logic [3:0]        todo_after;
    logic [2:0]        bund_west_reg;
    logic [2:0]        bund_ctr_reg;
    logic [2:0]        bund_east_reg;
    logic [ROW_W-1:0]  bund_row_reg;
    logic [COL_W-1:0]  bund_col_reg;
    logic              out_free;
    logic              emit;
    slot_t             sel;
    logic [3:0]        e_ctr;
    logic [3:0]        e_west;
    logic [3:0]        e_east;
    logic [1:0]        e_k;
    logic [ROW_W-1:0]  e_row;
    logic [COL_W-1:0]  e_col;
    logic              e_last;
    logic              e_self;
    logic [MASK_W-1:0] e_mask;
    logic [DEG_W-1:0]  e_deg;
    logic [VSUM_W-1:0] vsum_reg;
    logic [DSUM_W-1:0] dsum_reg;
    logic [VSUM_W-1:0] vsum_next;
    logic [DSUM_W-1:0] dsum_next;

    // Output register
    logic              out_valid_reg;
    logic [COORD_W-1:0] out_row_reg;
    logic [COORD_W-1:0] out_col_reg;
    logic              out_pass_reg;
    logic [MASK_W-1:0] out_mask_reg;
    logic [DEG_W-1:0]  out_deg_reg;
    logic [VSUM_W-1:0] out_vsum_reg;
    logic [DSUM_W-1:0] out_dsum_reg;
    logic              out_last_reg;

    //------------------------------------------------------------------
    // Configuration registers
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_MAX;
            height_reg <= HEIGHT_MAX;
            rock_reg   <= ROCK_RESET;
            water_reg  <= WATER_RESET;
            crater_reg <= CRATER_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_WIDTH:  width_reg  <= cfg_data;
                REG_GRID_HEIGHT: height_reg <= cfg_data;
                REG_ROCK_CODE:   rock_reg   <= cfg_data[TILE_W-1:0];
                REG_WATER_CODE:  water_reg  <= cfg_data[TILE_W-1:0];
                REG_CRATER_CODE: crater_reg <= cfg_data[TILE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            width_eff = SIZE_W'(1);
        else if (width_reg > WIDTH_MAX)
            width_eff = WIDTH_MAX;
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = SIZE_W'(1);
        else if (height_reg > HEIGHT_MAX)
            height_eff = HEIGHT_MAX;
        else
            height_eff = height_reg;
    end

    //------------------------------------------------------------------
    // Input stage: raster position and passability
    //------------------------------------------------------------------
    assign in_fire     = tiles.valid && tiles.ready;
    assign in_pass     = (tiles.tile != rock_reg) && (tiles.tile != water_reg)
                         && (tiles.tile != crater_reg);
    assign in_end_row  = (SIZE_W'(col_reg) + SIZE_W'(1)) >= width_eff;
    assign in_last_row = (SIZE_W'(row_reg) + SIZE_W'(1)) >= height_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_fire)
        begin
            if (in_end_row)
            begin
                col_reg <= '0;
                row_reg <= in_last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
    end

    //------------------------------------------------------------------
    // Line store: read on accept, written when the item leaves the stage
    //------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
            rd_data_reg <= line_mem[col_reg];
        if (b_fire)
            line_mem[b_col_reg] <= ls_wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            // A read that meets the write of the same entry in one cycle sees old data.
            if (in_fire)
                fwd_reg <= b_fire && (col_reg == b_col_reg);
            if (in_fire)
                b_valid_reg <= 1'b1;
            else if (b_fire)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            fwd_data_reg   <= ls_wr;
            b_pass_reg     <= in_pass;
            b_row_reg      <= row_reg;
            b_col_reg      <= col_reg;
            b_end_row_reg  <= in_end_row;
            b_last_row_reg <= in_last_row;
        end
    end

    assign ls    = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign ls_wr = {ls[0], b_pass_reg};

    // Column bits: bit0 two rows up, bit1 one row up, bit2 current row.
    always_comb
    begin
        col_bits[0] = ls[1] && (b_row_reg > ROW_W'(1));
        col_bits[1] = ls[0] && (b_row_reg != '0);
        col_bits[2] = b_pass_reg;

        if (b_col_reg == '0)
            window_next = {col_bits, 6'b0};
        else
            window_next = {col_bits, window_reg[8:3]};

        todo_new[0] = (b_row_reg != '0) && (b_col_reg != '0);
        todo_new[1] = (b_row_reg != '0) && b_end_row_reg;
        todo_new[2] = b_last_row_reg && (b_col_reg != '0);
        todo_new[3] = b_last_row_reg && b_end_row_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= '0;
        else if (b_fire)
            window_reg <= (b_last_row_reg && b_end_row_reg) ? '0 : window_next;
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            bund_west_reg <= window_next[2:0];
            bund_ctr_reg  <= window_next[5:3];
            bund_east_reg <= window_next[8:6];
            bund_row_reg  <= b_row_reg;
            bund_col_reg  <= b_col_reg;
        end
    end

    //------------------------------------------------------------------
    // Emitter: one result per cycle when not stalled, from the pending slots, lowest first
    //------------------------------------------------------------------
    assign out_free   = !out_valid_reg || results.ready;
    assign emit       = (todo_reg != '0) && out_free;
    assign todo_after = emit ? (todo_reg & (todo_reg - 4'd1)) : todo_reg;
    assign b_fire     = b_valid_reg && (todo_after == '0);
    assign tiles.ready = !b_valid_reg || b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            todo_reg <= '0;
        else
            todo_reg <= b_fire ? todo_new : todo_after;
    end

    always_comb
    begin
        if (todo_reg[0])
            sel = SLOT_UPPER_PREV;
        else if (todo_reg[1])
            sel = SLOT_UPPER_EDGE;
        else if (todo_reg[2])
            sel = SLOT_LOWER_PREV;
        else
            sel = SLOT_LOWER_EDGE;

        case (sel)
            SLOT_UPPER_PREV:
            begin
                e_ctr  = {1'b0, bund_ctr_reg};
                e_west = {1'b0, bund_west_reg};
                e_east = {1'b0, bund_east_reg};
                e_k    = 2'd1;
                e_row  = bund_row_reg - ROW_W'(1);
                e_col  = bund_col_reg - COL_W'(1);
                e_last = 1'b0;
            end
            SLOT_UPPER_EDGE:
            begin
                e_ctr  = {1'b0, bund_east_reg};
                e_west = {1'b0, bund_ctr_reg};
                e_east = '0;
                e_k    = 2'd1;
                e_row  = bund_row_reg - ROW_W'(1);
                e_col  = bund_col_reg;
                e_last = 1'b0;
            end
            SLOT_LOWER_PREV:
            begin
                e_ctr  = {1'b0, bund_ctr_reg};
                e_west = {1'b0, bund_west_reg};
                e_east = {1'b0, bund_east_reg};
                e_k    = 2'd2;
                e_row  = bund_row_reg;
                e_col  = bund_col_reg - COL_W'(1);
                e_last = 1'b0;
            end
            default:
            begin
                e_ctr  = {1'b0, bund_east_reg};
                e_west = {1'b0, bund_ctr_reg};
                e_east = '0;
                e_k    = 2'd2;
                e_row  = bund_row_reg;
                e_col  = bund_col_reg;
                e_last = 1'b1;
            end
        endcase

        e_self = e_ctr[e_k];
        e_mask[0] = e_east[e_k];
        e_mask[1] = e_west[e_k];
        e_mask[2] = e_ctr[e_k + 2'd1];
        e_mask[3] = e_ctr[e_k - 2'd1];
        e_mask[4] = e_east[e_k + 2'd1];
        e_mask[5] = e_west[e_k + 2'd1];
        e_mask[6] = e_east[e_k - 2'd1];
        e_mask[7] = e_west[e_k - 2'd1];
        if (!e_self)
            e_mask = '0;

        e_deg = '0;
        for (int i = 0; i < MASK_W; i++)
            e_deg = e_deg + DEG_W'(e_mask[i]);

        vsum_next = vsum_reg + VSUM_W'(e_deg != '0);
        dsum_next = dsum_reg + DSUM_W'(e_deg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vsum_reg      <= '0;
            dsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                vsum_reg <= e_last ? '0 : vsum_next;
                dsum_reg <= e_last ? '0 : dsum_next;
            end
            if (emit)
                out_valid_reg <= 1'b1;
            else if (results.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_row_reg  <= COORD_W'(e_row);
            out_col_reg  <= COORD_W'(e_col);
            out_pass_reg <= e_self;
            out_mask_reg <= e_mask;
            out_deg_reg  <= e_deg;
            out_vsum_reg <= vsum_next;
            out_dsum_reg <= dsum_next;
            out_last_reg <= e_last;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.cell_row      = out_row_reg;
    assign results.cell_col      = out_col_reg;
    assign results.passable      = out_pass_reg;
    assign results.neighbor_mask = out_mask_reg;
    assign results.degree        = out_deg_reg;
    assign results.vertex_total  = out_vsum_reg;
    assign results.degree_total  = out_dsum_reg;
    assign results.last          = out_last_reg;

`ifndef SYNTHESIS
    // Totals restart once the final cell of the grid has been emitted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit && e_last) |=> (vsum_reg == '0 && dsum_reg == '0))
        else $error("running totals not cleared after the last cell");

    // The degree always matches the population of the mask.
    assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.degree == DEG_W'($countones(results.neighbor_mask))))
        else $error("degree does not match neighbor mask");

    // A blocked cell reports no neighbors.
    assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.passable) |-> (results.neighbor_mask == '0))
        else $error("blocked cell reports passable neighbors");

    // The memory stage never releases its item while the emitter still has slots left
    // after the emission of this cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        b_fire |-> (todo_after == '0))
        else $error("memory stage released over pending results");
`endif

endmodule

FILE: sim/tb_grid_neighbor_adjacency_mask.sv
// Self-checking testbench for the grid neighbor adjacency mask block.
module tb_grid_neighbor_adjacency_mask;
    timeunit 1ns;
    timeprecision 1ps;

    import gnam_pkg::*;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 8;

    typedef struct packed {
        logic [COORD_W-1:0] cell_row;
        logic [COORD_W-1:0] cell_col;
        logic               passable;
        logic [MASK_W-1:0]  neighbor_mask;
        logic [DEG_W-1:0]   degree;
        logic [VSUM_W-1:0]  vertex_total;
        logic [DSUM_W-1:0]  degree_total;
        logic               last;
    } cell_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    gnam_tile_if   tile_ch ();
    gnam_result_if result_ch ();

    grid_neighbor_adjacency_mask u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tiles     (tile_ch),
        .results   (result_ch)
    );

    // Shadow copy of the configuration and of the raster state.
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic [TILE_W-1:0] rock_reg;
    logic [TILE_W-1:0] water_reg;
    logic [TILE_W-1:0] crater_reg;
    logic [1:0]        line_bits [MAX_WIDTH];
    logic [8:0]        window;
    int unsigned       row_pos;
    int unsigned       col_pos;
    logic [VSUM_W-1:0] vertex_acc;
    logic [DSUM_W-1:0] degree_acc;

    logic [TILE_W-1:0] tile_backlog [$];
    cell_result_t      pending_cells [$];
    int unsigned       tiles_queued;
    int unsigned       tiles_accepted;
    int unsigned       error_count;
    int unsigned       hold_requests;
    int unsigned       holds_done;
    int unsigned       idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned lim);
        if (v == 0)
            return 1;
        if (v > lim)
            return lim;
        return v;
    endfunction

    task automatic report_error(input string msg);
        if (error_count < 40)
            $display("ERROR %s", msg);
        error_count++;
    endtask

    // Columns hold row bits: bit0 two rows up, bit1 one row up, bit2 the current row.
    // k picks the center row of the cell being described.
    task automatic record_cell(input logic [3:0] ctr, input logic [3:0] west,
                               input logic [3:0] east, input int k,
                               input int unsigned row, input int unsigned col,
                               input logic fin);
        cell_result_t res;
        logic [7:0]   m;
        m = '0;
        if (ctr[k])
            m = {west[k-1], east[k-1], west[k+1], east[k+1],
                 ctr[k-1], ctr[k+1], west[k], east[k]};
        if (m != 0)
            vertex_acc = vertex_acc + VSUM_W'(1);
        degree_acc = degree_acc + DSUM_W'($countones(m));
        res.cell_row      = row[COORD_W-1:0];
        res.cell_col      = col[COORD_W-1:0];
        res.passable      = ctr[k];
        res.neighbor_mask = m;
        res.degree        = DEG_W'($countones(m));
        res.vertex_total  = vertex_acc;
        res.degree_total  = degree_acc;
        res.last          = fin;
        pending_cells.insert(pending_cells.size(), res);
    endtask

    task automatic compute_neighbors(input logic [TILE_W-1:0] tile);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        logic        p;
        logic [1:0]  ls;
        logic [3:0]  colbits;
        logic [3:0]  wcol;
        logic [3:0]  ccol;
        logic [3:0]  ecol;
        logic        end_row;
        logic        last_row;
        w = eff_size(width_reg, MAX_WIDTH);
        h = eff_size(height_reg, MAX_HEIGHT);
        r = row_pos;
        c = col_pos;
        if (c >= MAX_WIDTH)
            c = MAX_WIDTH - 1;
        p = (tile != rock_reg) && (tile != water_reg) && (tile != crater_reg);
        ls = line_bits[c];
        colbits = {1'b0, p, ls[0], ls[1]};
        // Rows above the top of the grid read as blocked.
        if (r < 2)
            colbits[0] = 1'b0;
        if (r < 1)
            colbits[1] = 1'b0;
        line_bits[c] = {ls[0], p};
        if (c == 0)
            window = '0;
        window = {colbits[2:0], window[8:3]};
        wcol = {1'b0, window[2:0]};
        ccol = {1'b0, window[5:3]};
        ecol = {1'b0, window[8:6]};
        end_row  = (c + 1 >= w);
        last_row = (r + 1 >= h);
        if (r >= 1)
        begin
            if (c >= 1)
                record_cell(ccol, wcol, ecol, 1, r - 1, c - 1, 1'b0);
            if (end_row)
                record_cell(ecol, ccol, 4'd0, 1, r - 1, c, 1'b0);
        end
        if (last_row)
        begin
            if (c >= 1)
                record_cell(ccol, wcol, ecol, 2, r, c - 1, 1'b0);
            if (end_row)
                record_cell(ecol, ccol, 4'd0, 2, r, c, 1'b1);
        end
        if (end_row)
        begin
            col_pos = 0;
            if (last_row)
            begin
                row_pos    = 0;
                window     = '0;
                vertex_acc = '0;
                degree_acc = '0;
            end
            else
                row_pos = r + 1;
        end
        else
            col_pos = c + 1;
    endtask

    task automatic check_field(input string name, input logic [DSUM_W-1:0] got,
                               input logic [DSUM_W-1:0] want, input cell_result_t exp_res);
        if (got !== want)
            report_error($sformatf("cell (%0d,%0d) %s: got %0h, expected %0h",
                                   exp_res.cell_row, exp_res.cell_col, name, got, want));
    endtask

    // Tile driver: bursts of random length separated by random gaps.
    int unsigned burst_left;
    int unsigned gap_left;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            tile_ch.valid <= 1'b0;
            tile_ch.tile  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (tile_ch.valid && tile_ch.ready)
            begin
                compute_neighbors(tile_ch.tile);
                tiles_accepted++;
            end
            if (!tile_ch.valid || tile_ch.ready)
            begin
                if (burst_left == 0 && gap_left == 0)
                begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                              : $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                end
                if (burst_left > 0 && tile_backlog.size() > 0)
                begin
                    tile_ch.valid <= 1'b1;
                    tile_ch.tile  <= tile_backlog.pop_front();
                    burst_left--;
                end
                else
                begin
                    tile_ch.valid <= 1'b0;
                    if (burst_left == 0 && gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Result monitor with its own stall pattern and an occasional long hold-off.
    int unsigned  stall_mode;
    int unsigned  mode_left;
    int unsigned  hold_left;
    int unsigned  pattern_idx;
    logic [6:0]   stall_pattern;
    cell_result_t want;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_mode    = 0;
            mode_left     = 0;
            hold_left     = 0;
            pattern_idx   = 0;
            stall_pattern = 7'b1011001;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_cells.size() == 0)
                    report_error($sformatf("result for cell (%0d,%0d) with none expected",
                                           result_ch.cell_row, result_ch.cell_col));
                else
                begin
                    want = pending_cells.pop_front();
                    check_field("cell_row", result_ch.cell_row, want.cell_row, want);
                    check_field("cell_col", result_ch.cell_col, want.cell_col, want);
                    check_field("passable", result_ch.passable, want.passable, want);
                    check_field("neighbor_mask", result_ch.neighbor_mask,
                                want.neighbor_mask, want);
                    check_field("degree", result_ch.degree, want.degree, want);
                    check_field("vertex_total", result_ch.vertex_total,
                                want.vertex_total, want);
                    check_field("degree_total", result_ch.degree_total,
                                want.degree_total, want);
                    check_field("last", result_ch.last, want.last, want);
                end
            end
            if (holds_done != hold_requests)
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(16, 96);
            end
            else
                mode_left--;
            pattern_idx = (pattern_idx + 1) % 7;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_mode == 2)
                result_ch.ready <= 1'($urandom_range(0, 1));
            else if (stall_mode == 3)
                result_ch.ready <= stall_pattern[pattern_idx];
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((tile_ch.valid && tile_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no request accepted for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_GRID_WIDTH:  width_reg  = val;
            REG_GRID_HEIGHT: height_reg = val;
            REG_ROCK_CODE:   rock_reg   = val[TILE_W-1:0];
            REG_WATER_CODE:  water_reg  = val[TILE_W-1:0];
            REG_CRATER_CODE: crater_reg = val[TILE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic queue_tile(input logic [TILE_W-1:0] t);
        tile_backlog.insert(tile_backlog.size(), t);
        tiles_queued++;
    endtask

    // Waits until every tile is taken and every result is in, then lets the pipeline drain.
    task automatic wait_idle();
        while (tiles_accepted != tiles_queued || pending_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [TILE_W-1:0] pick_tile(input int unsigned blocked_pct);
        if ($urandom_range(0, 99) < blocked_pct)
        begin
            case ($urandom_range(0, 2))
                0:       return rock_reg;
                1:       return water_reg;
                default: return crater_reg;
            endcase
        end
        return TILE_W'($urandom_range(0, 255));
    endfunction

    task automatic queue_grid(input int unsigned n, input int unsigned blocked_pct);
        repeat (n) queue_tile(pick_tile(blocked_pct));
    endtask

    initial
    begin
        int unsigned random_tiles;
        int unsigned n;
        int unsigned blocked_pct;
        logic [TILE_W-1:0] code;

        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = REG_GRID_WIDTH;
        cfg_data        = '0;
        tile_ch.valid   = 1'b0;
        tile_ch.tile    = '0;
        result_ch.ready = 1'b0;
        width_reg       = WIDTH_MAX;
        height_reg      = HEIGHT_MAX;
        rock_reg        = ROCK_RESET;
        water_reg       = WATER_RESET;
        crater_reg      = CRATER_RESET;
        window          = '0;
        row_pos         = 0;
        col_pos         = 0;
        vertex_acc      = '0;
        degree_acc      = '0;
        tiles_queued    = 0;
        tiles_accepted  = 0;
        error_count     = 0;
        hold_requests   = 0;
        holds_done      = 0;
        random_tiles    = 0;
        for (int i = 0; i < MAX_WIDTH; i++)
            line_bits[i] = 2'b00;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Zero sizes act as a single cell; coinciding codes still block.
        write_reg(REG_GRID_WIDTH, 9'd0);
        write_reg(REG_GRID_HEIGHT, 9'd0);
        write_reg(REG_ROCK_CODE, 9'd0);
        write_reg(REG_WATER_CODE, 9'd255);
        write_reg(REG_CRATER_CODE, 9'd0);
        queue_tile(8'd0);
        queue_tile(8'd255);
        queue_tile(8'd7);
        wait_idle();

        // 3x3 all open gives a full mask in the center, then a mixed map.
        write_reg(REG_GRID_WIDTH, 9'd3);
        write_reg(REG_GRID_HEIGHT, 9'd3);
        write_reg(REG_ROCK_CODE, 9'd1);
        write_reg(REG_WATER_CODE, 9'd2);
        write_reg(REG_CRATER_CODE, 9'd3);
        queue_tile(8'd0);
        queue_tile(8'd255);
        queue_tile(8'd4);
        queue_tile(8'd5);
        queue_tile(8'd128);
        queue_tile(8'd127);
        queue_tile(8'd64);
        queue_tile(8'd8);
        queue_tile(8'd16);
        queue_tile(8'd1);
        queue_tile(8'd9);
        queue_tile(8'd2);
        queue_tile(8'd0);
        queue_tile(8'd3);
        queue_tile(8'd0);
        queue_tile(8'd9);
        queue_tile(8'd1);
        queue_tile(8'd200);
        wait_idle();

        // One column: the same line store entry is read on every tile.
        write_reg(REG_GRID_WIDTH, 9'd1);
        write_reg(REG_GRID_HEIGHT, 9'd4);
        queue_tile(8'd10);
        queue_tile(8'd1);
        queue_tile(8'd20);
        queue_tile(8'd30);
        wait_idle();

        // Oversized grid shrunk while in progress: the row ends early, then the grid.
        write_reg(REG_GRID_WIDTH, 9'd511);
        write_reg(REG_GRID_HEIGHT, 9'd400);
        queue_grid(10, 30);
        wait_idle();
        write_reg(REG_GRID_WIDTH, 9'd6);
        queue_grid(16, 30);
        wait_idle();
        write_reg(REG_GRID_HEIGHT, 9'd2);
        queue_grid(3, 30);
        wait_idle();

        while (random_tiles < 150)
        begin
            if (random_tiles == 0 || $urandom_range(0, 1) == 0)
            begin
                wait_idle();
                case ($urandom_range(0, 9))
                    0:       write_reg(REG_GRID_WIDTH, 9'd1);
                    1:       write_reg(REG_GRID_WIDTH, 9'd0);
                    2:       write_reg(REG_GRID_WIDTH, 9'($urandom_range(13, 40)));
                    default: write_reg(REG_GRID_WIDTH, 9'($urandom_range(2, 12)));
                endcase
                case ($urandom_range(0, 5))
                    0:       write_reg(REG_GRID_HEIGHT, 9'd1);
                    1:       write_reg(REG_GRID_HEIGHT, 9'd0);
                    default: write_reg(REG_GRID_HEIGHT, 9'($urandom_range(2, 7)));
                endcase
                if ($urandom_range(0, 2) == 0)
                begin
                    code = TILE_W'($urandom_range(0, 255));
                    write_reg(REG_ROCK_CODE, 9'(code));
                    write_reg(REG_WATER_CODE, ($urandom_range(0, 3) == 0) ? 9'(code)
                                              : 9'($urandom_range(0, 255)));
                    write_reg(REG_CRATER_CODE, 9'($urandom_range(0, 255)));
                end
            end
            n = eff_size(width_reg, MAX_WIDTH) * eff_size(height_reg, MAX_HEIGHT);
            blocked_pct = $urandom_range(0, 60);
            queue_grid(n, blocked_pct);
            random_tiles += n;
            if (n >= 30 && hold_requests == 0)
                hold_requests++;
        end
        wait_idle();

        // Full-width single row: all but the first tile yield results; a hold backs it up.
        write_reg(REG_GRID_WIDTH, 9'd256);
        write_reg(REG_GRID_HEIGHT, 9'd1);
        queue_grid(256, 25);
        hold_requests++;

        wait_idle();
        repeat (24) @(posedge clk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
